// File: design/btc_pkg.sv
// Shared types, constants and codes of the token compactor.
`default_nettype none
package btc_pkg;

    // Stack depths and derived widths.
    localparam int PENDING_DEPTH = 32;
    localparam int LOOP_DEPTH    = 64;
    localparam int PIDX_W  = $clog2(PENDING_DEPTH);
    localparam int PFILL_W = $clog2(PENDING_DEPTH + 1);
    localparam int LIDX_W  = $clog2(LOOP_DEPTH);
    localparam int LFILL_W = $clog2(LOOP_DEPTH + 1);

    // Result kinds.
    localparam logic [2:0] KIND_BYTECODE  = 3'd0;
    localparam logic [2:0] KIND_BAD_CHAR  = 3'd1;
    localparam logic [2:0] KIND_UNMATCHED = 3'd2;
    localparam logic [2:0] KIND_UNCLOSED  = 3'd3;
    localparam logic [2:0] KIND_PEND_OVF  = 3'd4;
    localparam logic [2:0] KIND_LOOP_OVF  = 3'd5;
    localparam logic [2:0] KIND_END       = 3'd6;

    // Opcodes.
    localparam logic [2:0] OP_PLUS   = 3'd0;
    localparam logic [2:0] OP_MINUS  = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_LEFT   = 3'd3;
    localparam logic [2:0] OP_OPEN   = 3'd4;
    localparam logic [2:0] OP_CLOSE  = 3'd5;
    localparam logic [2:0] OP_OUTPUT = 3'd6;
    localparam logic [2:0] OP_INPUT  = 3'd7;

    // Source characters.
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [15:0] POS_MAX = 16'hFFFF;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  opcode;
        logic [15:0] argument;
        logic [15:0] error_line;
        logic [15:0] error_column;
        logic        last_of_run;
    } out_item_t;

    // One pending run: op (plus, minus, right, left) and its count.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] cnt;
    } pend_entry_t;

    // Per-cell shift control.
    typedef struct packed {
        logic take_prev;
        logic take_next;
    } cell_ctl_t;

    // Request from the sequencer to the pending chain.
    typedef struct packed {
        logic       op_valid;
        logic [1:0] op;
        logic       flush_pop;
    } pend_req_t;

    // Status from the pending chain.
    typedef struct packed {
        logic [PFILL_W-1:0] fill;
        pend_entry_t        flush_entry;
        logic               overflow;
    } pend_stat_t;

endpackage
`default_nettype wire

// File: design/btc_cell.sv
// One cell of the pending run chain: holds one entry and shifts to a neighbor.
`default_nettype none
module btc_cell (
    input  wire logic                clk,
    input  wire btc_pkg::cell_ctl_t  ctl,
    input  wire btc_pkg::pend_entry_t prev_entry,
    input  wire btc_pkg::pend_entry_t next_entry,
    output btc_pkg::pend_entry_t     entry
);
    import btc_pkg::*;

    pend_entry_t entry_reg;
    pend_entry_t entry_next;

    // Take the entry from the cell above, the cell below, or hold.
    always_comb
    begin
        if (ctl.take_prev)
        begin
            entry_next = prev_entry;
        end
        else if (ctl.take_next)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

// File: design/btc_pending.sv
// Pending run stack built as a chain of cells with the top entry in cell zero.
`default_nettype none
module btc_pending (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire btc_pkg::pend_req_t  req,
    output btc_pkg::pend_stat_t      stat
);
    import btc_pkg::*;

    pend_entry_t        cell_q [PENDING_DEPTH];
    pend_entry_t        new_top;
    cell_ctl_t          ctl0;
    cell_ctl_t          ctl_rest;
    logic [PFILL_W-1:0] fill_reg;
    logic [PFILL_W-1:0] fill_next;
    logic               have_top;
    logic               same_op;
    logic               opp_op;
    logic               overflow;

    // Decide how a run op changes the top entry and how a flush pop changes the fill.
    always_comb
    begin
        have_top  = (fill_reg != '0);
        same_op   = have_top && (cell_q[0].op == req.op) && (cell_q[0].cnt != CNT_MAX);
        opp_op    = have_top && (cell_q[0].op == (req.op ^ 2'd1));
        new_top   = cell_q[0];
        ctl0      = '0;
        ctl_rest  = '0;
        fill_next = fill_reg;
        overflow  = 1'b0;
        if (req.op_valid)
        begin
            if (same_op)
            begin
                new_top.cnt    = cell_q[0].cnt + 16'd1;
                ctl0.take_prev = 1'b1;
            end
            else if (opp_op)
            begin
                if (cell_q[0].cnt == 16'd1)
                begin
                    ctl0.take_next     = 1'b1;
                    ctl_rest.take_next = 1'b1;
                    fill_next          = fill_reg - 1'b1;
                end
                else
                begin
                    new_top.cnt    = cell_q[0].cnt - 16'd1;
                    ctl0.take_prev = 1'b1;
                end
            end
            else if (fill_reg < PFILL_W'(PENDING_DEPTH))
            begin
                new_top.op         = req.op;
                new_top.cnt        = 16'd1;
                ctl0.take_prev     = 1'b1;
                ctl_rest.take_prev = 1'b1;
                fill_next          = fill_reg + 1'b1;
            end
            else
            begin
                overflow = 1'b1;
            end
        end
        else if (req.flush_pop && have_top)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // The row of cells.
    for (genvar i = 0; i < PENDING_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            btc_cell u_cell (
                .clk        (clk),
                .ctl        (ctl0),
                .prev_entry (new_top),
                .next_entry (cell_q[(i + 1) % PENDING_DEPTH]),
                .entry      (cell_q[i])
            );
        end
        else if (i == PENDING_DEPTH - 1)
        begin : g_last
            btc_cell u_cell (
                .clk        (clk),
                .ctl        (ctl_rest),
                .prev_entry (cell_q[i - 1]),
                .next_entry (cell_q[i]),
                .entry      (cell_q[i])
            );
        end
        else
        begin : g_mid
            btc_cell u_cell (
                .clk        (clk),
                .ctl        (ctl_rest),
                .prev_entry (cell_q[i - 1]),
                .next_entry (cell_q[i + 1]),
                .entry      (cell_q[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // Flushing reads the bottom entry, which sits at the deepest filled cell.
    assign stat.fill        = fill_reg;
    assign stat.flush_entry = cell_q[PIDX_W'(fill_reg - 1'b1)];
    assign stat.overflow    = overflow;

endmodule
`default_nettype wire

// File: design/bf_token_compactor_top.sv
// Top level of the token compactor: lexer, pending run stack, loop id stack and result sequencer.
//
//   Channel | Signals                          | Payload
//   source  | src_valid, src_ready, src_item   | btc_pkg::in_item_t
//   result  | res_valid, res_ready, res_item   | btc_pkg::out_item_t
//
// A byte that makes no result or only a run update or an error is handled in idle.
// A command byte first flushes the pending entries until the stack is seen empty,
// then issues the command. After the final byte the rest is flushed, then the
// unclosed report follows if loops are open, and last the end result.
// Reset clears all counters and fills; stack contents need no reset.
// A stalled result holds the sequencer; no new byte is taken until all results
// of the current byte have been loaded into the output register.
`default_nettype none
module bf_token_compactor_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire btc_pkg::in_item_t  src_item,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output btc_pkg::out_item_t      res_item
);
    import btc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FLUSH1 = 3'd1;
    localparam logic [2:0] S_CMD    = 3'd2;
    localparam logic [2:0] S_FLUSH2 = 3'd3;
    localparam logic [2:0] S_END    = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;
    logic               in_comment_reg, in_comment_next;
    logic [15:0]        line_reg, line_next;
    logic [15:0]        col_reg, col_next;
    logic [LFILL_W-1:0] loop_fill_reg, loop_fill_next;
    logic [15:0]        next_id_reg, next_id_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic               fin_reg, fin_next;

    logic [15:0]        loop_mem [LOOP_DEPTH];
    logic [15:0]        rd_data_reg;
    logic               mem_we;
    logic [LIDX_W-1:0]  rd_addr;

    pend_req_t          preq;
    pend_stat_t         pstat;
    logic               slot_free;
    logic               accept;
    logic [7:0]         b;
    logic               out_load;
    out_item_t          out_item;

    assign slot_free = !out_valid_reg || res_ready;
    assign src_ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = src_valid && src_ready;
    assign b         = src_item.source_byte;
    assign rd_addr   = LIDX_W'(loop_fill_reg - 1'b1);

    btc_pending u_pending (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (preq),
        .stat  (pstat)
    );

    // Sequencer: lexing on accept, then flush, command, final reports.
    always_comb
    begin
        state_next      = state_reg;
        in_comment_next = in_comment_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        loop_fill_next  = loop_fill_reg;
        next_id_next    = next_id_reg;
        cmd_next        = cmd_reg;
        fin_next        = fin_reg;
        preq            = '0;
        mem_we          = 1'b0;
        out_load        = 1'b0;
        out_item        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = b;
                    fin_next = src_item.final_byte;
                    state_next = src_item.final_byte ? S_FLUSH2 : S_IDLE;
                    if (in_comment_reg)
                    begin
                        if (b == CH_NEWLINE)
                        begin
                            in_comment_next = 1'b0;
                        end
                    end
                    else if (b == CH_HASH)
                    begin
                        in_comment_next = 1'b1;
                    end
                    else if (b inside {CH_SPACE, CH_TAB, CH_NEWLINE})
                    begin
                        in_comment_next = 1'b0;
                    end
                    else if (b inside {CH_PLUS, CH_MINUS, CH_GT, CH_LT})
                    begin
                        preq.op_valid = 1'b1;
                        case (b)
                            CH_PLUS:  preq.op = OP_PLUS[1:0];
                            CH_MINUS: preq.op = OP_MINUS[1:0];
                            CH_GT:    preq.op = OP_RIGHT[1:0];
                            default:  preq.op = OP_LEFT[1:0];
                        endcase
                        if (pstat.overflow)
                        begin
                            out_load             = 1'b1;
                            out_item.kind        = KIND_PEND_OVF;
                            out_item.opcode      = {1'b0, preq.op};
                            out_item.last_of_run = !src_item.final_byte;
                        end
                    end
                    else if (b inside {CH_LBRACK, CH_RBRACK, CH_DOT, CH_COMMA})
                    begin
                        state_next = S_FLUSH1;
                    end
                    else
                    begin
                        out_load              = 1'b1;
                        out_item.kind         = KIND_BAD_CHAR;
                        out_item.error_line   = line_reg;
                        out_item.error_column = col_reg;
                        out_item.last_of_run  = !src_item.final_byte;
                    end
                    // Position tracking, saturating.
                    if (b == CH_NEWLINE)
                    begin
                        if (line_reg != POS_MAX)
                        begin
                            line_next = line_reg + 16'd1;
                        end
                        col_next = 16'd1;
                    end
                    else if (col_reg != POS_MAX)
                    begin
                        col_next = col_reg + 16'd1;
                    end
                end
            end

            S_FLUSH1:
            begin
                if (slot_free)
                begin
                    if (pstat.fill != '0)
                    begin
                        preq.flush_pop  = 1'b1;
                        out_load        = 1'b1;
                        out_item.kind   = KIND_BYTECODE;
                        out_item.opcode = {1'b0, pstat.flush_entry.op};
                        out_item.argument = pstat.flush_entry.cnt;
                    end
                    else
                    begin
                        state_next = S_CMD;
                    end
                end
            end

            S_CMD:
            begin
                if (slot_free)
                begin
                    out_load             = 1'b1;
                    out_item.last_of_run = !fin_reg;
                    state_next           = fin_reg ? S_FLUSH2 : S_IDLE;
                    case (cmd_reg)
                        CH_LBRACK:
                        begin
                            out_item.opcode = OP_OPEN;
                            if (loop_fill_reg >= LFILL_W'(LOOP_DEPTH))
                            begin
                                out_item.kind = KIND_LOOP_OVF;
                            end
                            else
                            begin
                                mem_we            = 1'b1;
                                loop_fill_next    = loop_fill_reg + 1'b1;
                                next_id_next      = next_id_reg + 16'd1;
                                out_item.kind     = KIND_BYTECODE;
                                out_item.argument = next_id_reg;
                            end
                        end
                        CH_RBRACK:
                        begin
                            out_item.opcode = OP_CLOSE;
                            if (loop_fill_reg == '0)
                            begin
                                out_item.kind = KIND_UNMATCHED;
                            end
                            else
                            begin
                                loop_fill_next    = loop_fill_reg - 1'b1;
                                out_item.kind     = KIND_BYTECODE;
                                out_item.argument = rd_data_reg;
                            end
                        end
                        CH_DOT:
                        begin
                            out_item.kind   = KIND_BYTECODE;
                            out_item.opcode = OP_OUTPUT;
                        end
                        default:
                        begin
                            out_item.kind   = KIND_BYTECODE;
                            out_item.opcode = OP_INPUT;
                        end
                    endcase
                end
            end

            S_FLUSH2:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (pstat.fill != '0)
                    begin
                        preq.flush_pop    = 1'b1;
                        out_item.kind     = KIND_BYTECODE;
                        out_item.opcode   = {1'b0, pstat.flush_entry.op};
                        out_item.argument = pstat.flush_entry.cnt;
                    end
                    else if (loop_fill_reg != '0)
                    begin
                        out_item.kind     = KIND_UNCLOSED;
                        out_item.opcode   = OP_OPEN;
                        out_item.argument = 16'(loop_fill_reg);
                        state_next        = S_END;
                    end
                    else
                    begin
                        out_item.kind        = KIND_END;
                        out_item.last_of_run = 1'b1;
                        state_next           = S_IDLE;
                        loop_fill_next       = '0;
                        next_id_next         = '0;
                        line_next            = 16'd1;
                        col_next             = 16'd1;
                        in_comment_next      = 1'b0;
                    end
                end
            end

            S_END:
            begin
                if (slot_free)
                begin
                    out_load             = 1'b1;
                    out_item.kind        = KIND_END;
                    out_item.last_of_run = 1'b1;
                    state_next           = S_IDLE;
                    loop_fill_next       = '0;
                    next_id_next         = '0;
                    line_next            = 16'd1;
                    col_next             = 16'd1;
                    in_comment_next      = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_data_next = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = out_item;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            in_comment_reg <= 1'b0;
            line_reg       <= 16'd1;
            col_reg        <= 16'd1;
            loop_fill_reg  <= '0;
            next_id_reg    <= '0;
            fin_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            in_comment_reg <= in_comment_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            loop_fill_reg  <= loop_fill_next;
            next_id_reg    <= next_id_next;
            fin_reg        <= fin_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        cmd_reg      <= cmd_next;
    end

    // Loop id memory; the read port always follows the innermost open loop.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            loop_mem[loop_fill_reg[LIDX_W-1:0]] <= next_id_reg;
        end
        rd_data_reg <= loop_mem[rd_addr];
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_data_reg;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        src_ready |-> (state_reg == S_IDLE))
        else $error("source ready outside idle state");

    a_loop_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loop_fill_reg <= LFILL_W'(LOOP_DEPTH))
        else $error("loop fill beyond depth");

    a_cmd_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMD) |-> (pstat.fill == '0))
        else $error("command issued with pending runs");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_item.kind == KIND_END)
        |=> (loop_fill_reg == '0 && state_reg == S_IDLE))
        else $error("end result without state reset");
`endif

endmodule
`default_nettype wire
